[rtl/rmth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_pkg: shared types for the running median block
// controller commands and datapath status
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int VALUE_W  = 32;
    localparam int MEDIAN_W = 33;

    // heap operation requested from the datapath
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_REPLACE = 2'd1,
        OP_NONE    = 2'd2
    } t_heap_op;

    typedef struct packed {
        logic     latch;      // capture the incoming request value
        logic     start;      // begin the heap operation
        logic     heap_sel;   // 0: lower (max) heap, 1: upper (min) heap
        t_heap_op op;
    } t_cmd;

    typedef struct packed {
        logic busy;           // heap op in progress
        logic full;           // store holds CAPACITY values
        logic is_even;        // count parity before this request
        logic swap;           // the top must be replaced
    } t_status;

endpackage

[rtl/rmth_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_ram: generic single port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rmth_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_datapath: heap storage and sift engine
// two heap rams, sizes, parity, tops kept in registers, one sift unit
// ----------------------------------------------------------------------------
module rmth_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rmth_pkg::t_cmd                       i_cmd,
    input  logic signed [rmth_pkg::VALUE_W-1:0]  i_value,
    output rmth_pkg::t_status                    o_status,
    output logic signed [rmth_pkg::MEDIAN_W-1:0] o_median,
    output logic [$clog2(CAPACITY+1)-1:0]        o_count
);

    localparam int HDEPTH = CAPACITY / 2 + 1;
    localparam int AW     = $clog2(HDEPTH);
    localparam int SW     = $clog2(HDEPTH + 1);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int VW     = rmth_pkg::VALUE_W;
    localparam int XW     = AW + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_UPRD  = 6'b000010,  // push: read parent
        S_UPCMP = 6'b000100,
        S_DNRDL = 6'b001000,  // replace: read left child
        S_DNRDR = 6'b010000,  // read right child
        S_DNCMP = 6'b100000
    } t_sift;

    t_sift r_st, n_st;

    logic [SW-1:0] r_lsize, r_usize, n_lsize, n_usize;
    logic          r_even, n_even;
    logic signed [VW-1:0] r_ltop, r_utop, n_ltop, n_utop;
    logic          r_sel, n_sel;
    logic signed [VW-1:0] r_v, n_v;       // value being sifted
    logic signed [VW-1:0] r_val, n_val;   // request value
    logic signed [VW-1:0] r_move, n_move; // value pushed to the second heap
    logic [AW-1:0] r_i, n_i;
    logic signed [VW-1:0] r_lc, n_lc;
    logic          r_hasr, n_hasr;

    logic          we_l, we_u;
    logic [AW-1:0] addr;
    logic signed [VW-1:0] wdata;
    logic [VW-1:0] rd_l, rd_u;
    logic signed [VW-1:0] rd;
    logic [SW-1:0] size;
    logic [XW-1:0] lidx, ridx;
    logic [AW-1:0] par;
    logic          swap;

    rmth_ram #(.WIDTH(VW), .DEPTH(HDEPTH)) u_lower (
        .i_clk(i_clk), .i_we(we_l), .i_addr(addr), .i_wdata(wdata), .o_rdata(rd_l));
    rmth_ram #(.WIDTH(VW), .DEPTH(HDEPTH)) u_upper (
        .i_clk(i_clk), .i_we(we_u), .i_addr(addr), .i_wdata(wdata), .o_rdata(rd_u));

    assign rd   = r_sel ? $signed(rd_u) : $signed(rd_l);
    assign size = r_sel ? r_usize : r_lsize;
    assign lidx = {1'b0, r_i, 1'b1};
    assign ridx = lidx + 1'b1;
    assign par  = (r_i - 1'b1) >> 1;
    assign swap = r_even ? (r_lsize != '0 && r_ltop > i_value)
                         : (r_usize != '0 && r_utop < i_value);

    // a ranks above b in the selected heap
    function automatic logic above(input logic sel, input logic signed [VW-1:0] a,
                                   input logic signed [VW-1:0] b);
        above = sel ? (a < b) : (a > b);
    endfunction

    always_comb begin
        logic we;
        logic signed [VW-1:0] best;
        logic [AW-1:0] best_i;
        n_st = r_st; n_lsize = r_lsize; n_usize = r_usize; n_even = r_even;
        n_ltop = r_ltop; n_utop = r_utop; n_sel = r_sel; n_v = r_v; n_i = r_i;
        n_lc = r_lc; n_hasr = r_hasr; n_val = r_val; n_move = r_move;
        we = 1'b0; addr = r_i; wdata = r_v;
        best = r_v; best_i = r_i;
        if (i_cmd.latch) begin
            n_val  = i_value;
            n_move = i_value;
            // displaced top goes to the other heap
            if (swap) n_move = r_even ? r_ltop : r_utop;
        end
        unique case (r_st)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_sel = i_cmd.heap_sel;
                    unique case (i_cmd.op)
                        rmth_pkg::OP_PUSH: begin
                            n_v = r_move;
                            if (i_cmd.heap_sel) begin
                                n_i     = AW'(r_usize);
                                n_usize = r_usize + 1'b1;
                            end else begin
                                n_i     = AW'(r_lsize);
                                n_lsize = r_lsize + 1'b1;
                            end
                            n_even = ~r_even;
                            n_st   = S_UPRD;
                        end
                        rmth_pkg::OP_REPLACE: begin
                            n_v  = r_val;
                            n_i  = '0;
                            n_st = S_DNRDL;
                        end
                        default: ;
                    endcase
                end
            end
            S_UPRD: begin
                if (r_i == '0) begin
                    we = 1'b1; addr = '0; wdata = r_v;
                    if (r_sel) n_utop = r_v; else n_ltop = r_v;
                    n_st = S_IDLE;
                end else begin
                    addr = par;
                    n_st = S_UPCMP;
                end
            end
            S_UPCMP: begin
                we = 1'b1; addr = r_i;
                if (above(r_sel, r_v, rd)) begin
                    // move parent down, continue upward
                    wdata = rd;
                    n_i   = par;
                    n_st  = S_UPRD;
                end else begin
                    wdata = r_v;
                    n_st  = S_IDLE;
                end
            end
            S_DNRDL: begin
                if (lidx < XW'(size)) begin
                    addr   = lidx[AW-1:0];
                    n_hasr = ridx < XW'(size);
                    n_st   = S_DNRDR;
                end else begin
                    we = 1'b1; wdata = r_v;
                    if (r_i == '0) begin
                        if (r_sel) n_utop = r_v; else n_ltop = r_v;
                    end
                    n_st = S_IDLE;
                end
            end
            S_DNRDR: begin
                // rd holds left child here
                n_lc = rd;
                if (r_hasr) addr = ridx[AW-1:0];
                n_st = S_DNCMP;
            end
            S_DNCMP: begin
                // rd holds right child, r_lc the left
                if (above(r_sel, r_lc, best)) begin
                    best   = r_lc;
                    best_i = lidx[AW-1:0];
                end
                if (r_hasr && above(r_sel, rd, best)) begin
                    best   = rd;
                    best_i = ridx[AW-1:0];
                end
                we = 1'b1; wdata = best;
                if (r_i == '0) begin
                    if (r_sel) n_utop = best; else n_ltop = best;
                end
                n_i  = best_i;
                n_st = (best_i == r_i) ? S_IDLE : S_DNRDL;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
        we_l = we & ~r_sel;
        we_u = we & r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_lsize <= '0; r_usize <= '0; r_even <= 1'b1;
        end else begin
            r_st <= n_st; r_lsize <= n_lsize; r_usize <= n_usize; r_even <= n_even;
        end
        r_ltop <= n_ltop; r_utop <= n_utop; r_sel <= n_sel; r_v <= n_v;
        r_i <= n_i; r_lc <= n_lc; r_hasr <= n_hasr;
        r_val <= n_val; r_move <= n_move;
    end

    assign o_status.busy    = (r_st != S_IDLE);
    assign o_status.full    = (CW+1)'(r_lsize) + (CW+1)'(r_usize) >= (CW+1)'(CAPACITY);
    assign o_status.is_even = r_even;
    assign o_status.swap    = swap;
    assign o_count  = CW'(r_lsize) + CW'(r_usize);
    assign o_median = (r_usize == '0) ? '0 :
                      r_even ? ((r_lsize == '0) ? '0 :
                                 {r_ltop[VW-1], r_ltop} + {r_utop[VW-1], r_utop})
                             : {r_utop, 1'b0};

endmodule

[rtl/rmth_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_ctrl: request sequencer
// accepts a request, replaces on swap, pushes unless full, presents the result
// ----------------------------------------------------------------------------
module rmth_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  rmth_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic              o_dropped,
    output rmth_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_REPL = 4'b0010,
        C_PUSH = 4'b0100,
        C_OUT  = 4'b1000
    } t_ctl;

    t_ctl r_st, n_st;
    logic r_drop, n_drop;
    logic r_sel, n_sel;   // heap that gets the push

    always_comb begin
        n_st = r_st; n_drop = r_drop; n_sel = r_sel;
        o_cmd = '{latch: 1'b0, start: 1'b0, heap_sel: 1'b0, op: rmth_pkg::OP_NONE};
        unique case (r_st)
            C_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_drop = i_status.full;
                    n_sel = i_status.is_even;
                    if (i_status.full) begin
                        n_st = C_OUT;
                    end else if (i_status.swap) begin
                        n_st = C_REPL;
                    end else begin
                        n_st = C_PUSH;
                    end
                end
            end
            C_REPL: begin
                o_cmd = '{latch: 1'b0, start: 1'b1, heap_sel: ~r_sel,
                          op: rmth_pkg::OP_REPLACE};
                n_st = C_PUSH;
            end
            C_PUSH: begin
                if (!i_status.busy) begin
                    o_cmd = '{latch: 1'b0, start: 1'b1, heap_sel: r_sel,
                              op: rmth_pkg::OP_PUSH};
                    n_st = C_OUT;
                end
            end
            C_OUT: begin
                if (!i_status.busy && !i_out_stall) n_st = C_IDLE;
            end
            default: begin
                n_st = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_drop <= n_drop;
        r_sel  <= n_sel;
    end

    assign o_in_stall  = (r_st != C_IDLE);
    assign o_out_valid = (r_st == C_OUT) && !i_status.busy;
    assign o_dropped   = r_drop;

endmodule

[rtl/running_median_two_heaps.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps: streaming median over two bounded heaps
//
//   channel | handshake          | payload
//   in      | i_valid / o_stall  | i_value
//   out     | o_valid / i_stall  | o_median_doubled, o_stored_count,
//           |                    | o_dropped_full
//
// one request at a time; the sift unit works the heaps through one ram port:
// a replace reads the left child, then the right, then compares and writes
// for each heap level down; a push reads the parent, then compares and writes
// for each level up; a refused request (store full) skips the heap ops
// synchronous active low reset clears sizes and parity, not the heap rams
// the result holds while i_stall is high; the next request waits for it
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
    parameter int CAPACITY = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [rmth_pkg::VALUE_W-1:0]    i_value,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [rmth_pkg::MEDIAN_W-1:0]   o_median_doubled,
    output logic [$clog2(CAPACITY+1)-1:0]          o_stored_count,
    output logic                                   o_dropped_full
);

    rmth_pkg::t_cmd    cmd;
    rmth_pkg::t_status status;

    rmth_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_status(status), .o_in_stall(o_stall), .o_out_valid(o_valid),
        .o_dropped(o_dropped_full), .o_cmd(cmd));

    rmth_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_value(i_value),
        .o_status(status), .o_median(o_median_doubled), .o_count(o_stored_count));

endmodule
